FILE: rtl/assert_macros.svh
// assertion helpers included by rbpa_dpath
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// expression holds on every clock edge outside reset
`define RBPA_ASSERT_HOLDS(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define RBPA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define RBPA_ASSERT_HOLDS(lbl, clk, rstn, expr)
`define RBPA_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

FILE: rtl/rbpa_pkg.sv
package rbpa_pkg;

    // request opcodes
    localparam logic [1:0] OP_ALLOC_BLOCKS = 2'd0;
    localparam logic [1:0] OP_ALLOC_BYTES  = 2'd1;
    localparam logic [1:0] OP_TAKE         = 2'd2;
    localparam logic [1:0] OP_FREE         = 2'd3;

    // result status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FAIL  = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic set_fail;
        logic set_range;
        logic div_step;
        logic scan_init;
        logic scan_step;
        logic fill_step;
        logic head_rd;
        logic len_cap;
        logic walk_rd;
        logic walk_wr;
        logic finish;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic [1:0] op;
        logic       req_bad;
        logic       found;
        logic       miss;
        logic       fill_last;
        logic       len_zero;
        logic       walk_last;
        logic       out_free;
    } sts_t;

    typedef enum logic [9:0] {
        ST_IDLE    = 10'b00_0000_0001,
        ST_DECODE  = 10'b00_0000_0010,
        ST_DIV     = 10'b00_0000_0100,
        ST_SCAN    = 10'b00_0000_1000,
        ST_FILL    = 10'b00_0001_0000,
        ST_HEAD    = 10'b00_0010_0000,
        ST_LEN     = 10'b00_0100_0000,
        ST_WALK_RD = 10'b00_1000_0000,
        ST_WALK_WR = 10'b01_0000_0000,
        ST_DONE    = 10'b10_0000_0000
    } state_t;

endpackage

FILE: rtl/rbpa_ram.sv
module rbpa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/rbpa_ctrl.sv
module rbpa_ctrl import rbpa_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output cmd_t cmd,
    input  sts_t sts
);

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (sts.req_bad)
                begin
                    if (sts.op == OP_TAKE || sts.op == OP_FREE)
                    begin
                        cmd.set_range = 1'b1;
                    end
                    else
                    begin
                        cmd.set_fail = 1'b1;
                    end
                    state_next = ST_DONE;
                end
                else if (sts.op == OP_ALLOC_BLOCKS)
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = ST_SCAN;
                end
                else if (sts.op == OP_ALLOC_BYTES)
                begin
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_HEAD;
                end
            end
            ST_DIV:
            begin
                cmd.div_step  = 1'b1;
                cmd.scan_init = 1'b1;
                state_next    = ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.found)
                begin
                    state_next = ST_FILL;
                end
                else if (sts.miss)
                begin
                    cmd.set_fail = 1'b1;
                    state_next   = ST_DONE;
                end
            end
            ST_FILL:
            begin
                cmd.fill_step = 1'b1;
                if (sts.fill_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_HEAD:
            begin
                cmd.head_rd = 1'b1;
                state_next  = ST_LEN;
            end
            ST_LEN:
            begin
                cmd.len_cap = 1'b1;
                state_next  = sts.len_zero ? ST_DONE : ST_WALK_RD;
            end
            ST_WALK_RD:
            begin
                cmd.walk_rd = 1'b1;
                state_next  = ST_WALK_WR;
            end
            ST_WALK_WR:
            begin
                cmd.walk_wr = 1'b1;
                state_next  = sts.walk_last ? ST_DONE : ST_WALK_RD;
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/rbpa_dpath.sv
`include "assert_macros.svh"

module rbpa_dpath import rbpa_pkg::*; #(
    parameter int BLOCK_COUNT = 64,
    parameter int BLOCK_BYTES = 512
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [1:0]  in_opcode,
    input  logic [7:0]  in_block_count,
    input  logic [19:0] in_byte_count,
    input  logic [7:0]  in_start_block,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  out_status,
    output logic [7:0]  out_granted_block,
    output logic [7:0]  out_used_blocks,
    output logic [7:0]  out_free_blocks,
    input  cmd_t        cmd,
    output sts_t        sts
);

    localparam int AW     = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
    localparam int REM_W  = 21;
    localparam int DIV_W  = 24;
    localparam int RCP_W  = REM_W + 1;
    localparam int PROD_W = REM_W + RCP_W;
    localparam int RCP_SH = REM_W + $clog2(BLOCK_BYTES);
    localparam logic [DIV_W-1:0] POOL_BYTES = DIV_W'(BLOCK_COUNT * BLOCK_BYTES);
    localparam logic [AW-1:0]    LAST_IDX   = AW'(BLOCK_COUNT - 1);
    // rounded-up reciprocal, exact floor for every dividend below 2**REM_W
    localparam logic [RCP_W-1:0] RCP =
        RCP_W'(((64'd1 << RCP_SH) + 64'(BLOCK_BYTES) - 64'd1) / 64'(BLOCK_BYTES));

    // map entry: owner count above, run length below
    logic [15:0] ram_wdata;
    logic [15:0] ram_rdata;
    logic        ram_we;
    logic        ram_re;
    logic [AW-1:0] ram_waddr;
    logic [AW-1:0] ram_raddr;

    // control state
    logic [BLOCK_COUNT-1:0] vld_reg, vld_next;
    logic [7:0]  used_reg, used_next;
    logic        out_vld_reg, out_vld_next;
    logic        scan_more_reg, scan_more_next;
    logic        chk_vld_reg, chk_vld_next;

    // payload
    logic [1:0]       op_reg, op_next;
    logic [7:0]       start_reg, start_next;
    logic [7:0]       n_reg, n_next;
    logic             req_bad_reg, req_bad_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [1:0]       stat_reg, stat_next;
    logic [7:0]       grant_reg, grant_next;
    logic [AW-1:0]    scan_addr_reg, scan_addr_next;
    logic [AW-1:0]    chk_addr_reg, chk_addr_next;
    logic [7:0]       run_len_reg, run_len_next;
    logic [AW-1:0]    run_start_reg, run_start_next;
    logic [AW-1:0]    fill_addr_reg, fill_addr_next;
    logic [7:0]       fill_left_reg, fill_left_next;
    logic [AW-1:0]    cur_reg, cur_next;
    logic [7:0]       left_reg, left_next;
    logic             rd_vld_reg, rd_vld_next;
    logic [1:0]       out_stat_reg, out_stat_next;
    logic [7:0]       out_grant_reg, out_grant_next;
    logic [7:0]       out_used_reg, out_used_next;

    logic [15:0]       entry;
    logic [7:0]        ent_len;
    logic [7:0]        ent_cnt;
    logic [PROD_W-1:0] quot;
    logic              found;
    logic [AW-1:0]     found_addr;

    rbpa_ram #(
        .WIDTH (16),
        .DEPTH (BLOCK_COUNT)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // never-written entries read as free with no owner
    assign entry   = rd_vld_reg ? ram_rdata : 16'd0;
    assign ent_len = entry[7:0];
    assign ent_cnt = entry[15:8];

    // whole blocks for the rounded-up byte count, quotient fits 8 bits
    assign quot = (PROD_W'(rem_reg) * PROD_W'(RCP)) >> RCP_SH;

    assign found = chk_vld_reg && (ent_len == 8'd0)
                && (({1'b0, run_len_reg} + 9'd1) == {1'b0, n_reg});
    assign found_addr = (run_len_reg == 8'd0) ? chk_addr_reg : run_start_reg;

    always_comb
    begin
        sts.op        = op_reg;
        sts.req_bad   = req_bad_reg;
        sts.found     = found;
        sts.miss      = chk_vld_reg && !found && (chk_addr_reg == LAST_IDX);
        sts.fill_last = (fill_left_reg == 8'd1);
        sts.len_zero  = (ent_len == 8'd0);
        sts.walk_last = (left_reg == 8'd1) || (cur_reg == LAST_IDX);
        sts.out_free  = !out_vld_reg || out_ready;
    end

    // map port selection
    always_comb
    begin
        ram_re    = 1'b0;
        ram_raddr = scan_addr_reg;
        priority if (cmd.scan_step && scan_more_reg)
        begin
            ram_re = 1'b1;
        end
        else if (cmd.head_rd)
        begin
            ram_re    = 1'b1;
            ram_raddr = start_reg[AW-1:0];
        end
        else if (cmd.walk_rd)
        begin
            ram_re    = 1'b1;
            ram_raddr = cur_reg;
        end
    end

    always_comb
    begin
        vld_next       = vld_reg;
        used_next      = used_reg;
        out_vld_next   = out_vld_reg;
        scan_more_next = scan_more_reg;
        chk_vld_next   = chk_vld_reg;
        op_next        = op_reg;
        start_next     = start_reg;
        n_next         = n_reg;
        req_bad_next   = req_bad_reg;
        rem_next       = rem_reg;
        stat_next      = stat_reg;
        grant_next     = grant_reg;
        scan_addr_next = scan_addr_reg;
        chk_addr_next  = chk_addr_reg;
        run_len_next   = run_len_reg;
        run_start_next = run_start_reg;
        fill_addr_next = fill_addr_reg;
        fill_left_next = fill_left_reg;
        cur_next       = cur_reg;
        left_next      = left_reg;
        rd_vld_next    = rd_vld_reg;
        out_stat_next  = out_stat_reg;
        out_grant_next = out_grant_reg;
        out_used_next  = out_used_reg;
        ram_we         = 1'b0;
        ram_waddr      = fill_addr_reg;
        ram_wdata      = {8'd1, n_reg};

        if (ram_re)
        begin
            rd_vld_next = vld_reg[ram_raddr];
        end

        if (cmd.load)
        begin
            op_next      = in_opcode;
            start_next   = in_start_block;
            n_next       = in_block_count;
            rem_next     = {1'b0, in_byte_count} + REM_W'(BLOCK_BYTES - 1);
            stat_next    = STATUS_OK;
            grant_next   = 8'd0;
            unique case (in_opcode)
                OP_ALLOC_BLOCKS:
                    req_bad_next = (in_block_count == 8'd0)
                                || (in_block_count > 8'(BLOCK_COUNT));
                OP_ALLOC_BYTES:
                    req_bad_next = (in_byte_count == 20'd0)
                                || ({{(DIV_W-20){1'b0}}, in_byte_count} > POOL_BYTES);
                default:
                    req_bad_next = (in_start_block >= 8'(BLOCK_COUNT));
            endcase
        end

        if (cmd.set_fail)
        begin
            stat_next = STATUS_FAIL;
        end
        if (cmd.set_range)
        begin
            stat_next = STATUS_RANGE;
        end

        if (cmd.div_step)
        begin
            n_next = quot[7:0];
        end

        if (cmd.scan_init)
        begin
            scan_addr_next = '0;
            scan_more_next = 1'b1;
            chk_vld_next   = 1'b0;
            run_len_next   = 8'd0;
        end

        // first fit: one map read issued, one entry checked each cycle
        if (cmd.scan_step)
        begin
            chk_vld_next  = scan_more_reg;
            chk_addr_next = scan_addr_reg;
            if (scan_more_reg)
            begin
                if (scan_addr_reg == LAST_IDX)
                begin
                    scan_more_next = 1'b0;
                end
                else
                begin
                    scan_addr_next = scan_addr_reg + AW'(1);
                end
            end
            if (chk_vld_reg)
            begin
                if (ent_len == 8'd0)
                begin
                    run_len_next = run_len_reg + 8'd1;
                    if (run_len_reg == 8'd0)
                    begin
                        run_start_next = chk_addr_reg;
                    end
                end
                else
                begin
                    run_len_next = 8'd0;
                end
            end
            if (found)
            begin
                fill_addr_next = found_addr;
                fill_left_next = n_reg;
                grant_next     = 8'(found_addr);
            end
        end

        if (cmd.fill_step)
        begin
            ram_we                  = 1'b1;
            ram_waddr               = fill_addr_reg;
            ram_wdata               = {8'd1, n_reg};
            vld_next[fill_addr_reg] = 1'b1;
            fill_addr_next          = fill_addr_reg + AW'(1);
            fill_left_next          = fill_left_reg - 8'd1;
            used_next               = used_reg + 8'd1;
        end

        if (cmd.len_cap)
        begin
            cur_next  = start_reg[AW-1:0];
            left_next = ent_len;
        end

        // take or free one block of the run
        if (cmd.walk_wr)
        begin
            ram_we            = 1'b1;
            ram_waddr         = cur_reg;
            vld_next[cur_reg] = 1'b1;
            cur_next          = cur_reg + AW'(1);
            left_next         = left_reg - 8'd1;
            if (op_reg == OP_TAKE)
            begin
                ram_wdata = {(ent_cnt == 8'hFF) ? ent_cnt : ent_cnt + 8'd1, ent_len};
            end
            else if (ent_cnt <= 8'd1)
            begin
                ram_wdata = {ent_cnt, 8'd0};
                if (ent_len != 8'd0 && used_reg != 8'd0)
                begin
                    used_next = used_reg - 8'd1;
                end
            end
            else
            begin
                ram_wdata = {ent_cnt - 8'd1, ent_len};
            end
        end

        if (out_ready)
        begin
            out_vld_next = 1'b0;
        end
        if (cmd.finish)
        begin
            out_vld_next   = 1'b1;
            out_stat_next  = stat_reg;
            out_grant_next = grant_reg;
            out_used_next  = used_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            used_reg      <= 8'd0;
            out_vld_reg   <= 1'b0;
            scan_more_reg <= 1'b0;
            chk_vld_reg   <= 1'b0;
        end
        else
        begin
            vld_reg       <= vld_next;
            used_reg      <= used_next;
            out_vld_reg   <= out_vld_next;
            scan_more_reg <= scan_more_next;
            chk_vld_reg   <= chk_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        start_reg     <= start_next;
        n_reg         <= n_next;
        req_bad_reg   <= req_bad_next;
        rem_reg       <= rem_next;
        stat_reg      <= stat_next;
        grant_reg     <= grant_next;
        scan_addr_reg <= scan_addr_next;
        chk_addr_reg  <= chk_addr_next;
        run_len_reg   <= run_len_next;
        run_start_reg <= run_start_next;
        fill_addr_reg <= fill_addr_next;
        fill_left_reg <= fill_left_next;
        cur_reg       <= cur_next;
        left_reg      <= left_next;
        rd_vld_reg    <= rd_vld_next;
        out_stat_reg  <= out_stat_next;
        out_grant_reg <= out_grant_next;
        out_used_reg  <= out_used_next;
    end

    assign out_valid         = out_vld_reg;
    assign out_status        = out_stat_reg;
    assign out_granted_block = out_grant_reg;
    assign out_used_blocks   = out_used_reg;
    assign out_free_blocks   = 8'(BLOCK_COUNT) - out_used_reg;

    `RBPA_ASSERT_HOLDS(a_used_in_pool, clk, rst_n, used_reg <= 8'(BLOCK_COUNT))
    `RBPA_ASSERT_HOLDS(a_fill_in_run, clk, rst_n, !(cmd.fill_step && fill_left_reg == 8'd0))
    `RBPA_ASSERT_HOLDS(a_no_overwrite, clk, rst_n, !(cmd.finish && out_vld_reg && !out_ready))
    `RBPA_ASSERT_NEXT(a_finish_shows, clk, rst_n, cmd.finish, out_vld_reg)

endmodule

FILE: rtl/refcounted_block_pool_allocator.sv
// allocate blocks: decode, a first-fit scan of the map, then one map write per block of the run
// allocate bytes: adds a divide step, a reciprocal multiply that rounds up to whole blocks
// take ownership / free: reads the head entry for the run length, then one map read and one write per block
// one request in flight; the next one is taken the cycle after its result word is loaded
// a finished result word waits in the output register while the next request is taken
// reset (rst_n low, asynchronous) frees every block at once through per-block valid bits
module refcounted_block_pool_allocator import rbpa_pkg::*; #(
    parameter int BLOCK_COUNT = 64,
    parameter int BLOCK_BYTES = 512
) (
    input  logic        clk,
    input  logic        rst_n,
    // request words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // block_count[7:0], byte_count[27:8], start_block[35:28], zero
    input  logic [1:0]  s_tuser,   // opcode[1:0]
    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // granted_block[7:0], used_blocks[15:8], free_blocks[23:16]
    output logic [1:0]  m_tuser    // status[1:0]
);

    cmd_t cmd;
    sts_t sts;

    // sequencer: decode, divide, scan, fill, walk
    rbpa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // block map memory, counters and result register
    rbpa_dpath #(
        .BLOCK_COUNT (BLOCK_COUNT),
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_dpath (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_opcode         (s_tuser),
        .in_block_count    (s_tdata[7:0]),
        .in_byte_count     (s_tdata[27:8]),
        .in_start_block    (s_tdata[35:28]),
        .out_valid         (m_tvalid),
        .out_ready         (m_tready),
        .out_status        (m_tuser),
        .out_granted_block (m_tdata[7:0]),
        .out_used_blocks   (m_tdata[15:8]),
        .out_free_blocks   (m_tdata[23:16]),
        .cmd               (cmd),
        .sts               (sts)
    );

endmodule
